FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands for the checker file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every clock edge outside reset.
`define CHK_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("checker assertion failed");

// Checked at every clock edge, reset included.
`define CHK_ASSERT_NR(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("checker assertion failed");

`endif

FILE: rtl/arqrw_pkg.sv
// ----------------------------------------------------------------------------
// arqrw_pkg
// Shared widths, codes and types of the ARQ receiver window unit.
// ----------------------------------------------------------------------------
`default_nettype none

package arqrw_pkg;

  localparam int SEQ_W      = 3;   // sequence number field
  localparam int ACK_W      = 4;   // signed ack number
  localparam int WIN_W      = 3;   // window size register
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 3;
  localparam int WIN_MAX    = 4;
  localparam int QUEUE_DEPTH = 2;

  localparam int DEF_SEQ_SPACE     = 8;
  localparam int DEF_PAYLOAD_WIDTH = 64;

  localparam logic [WIN_W-1:0]        WIN_RESET = 3'd4;
  localparam logic signed [ACK_W-1:0] ACK_NONE  = -4'sd1;

  localparam logic KIND_DELIVER = 1'b0;
  localparam logic KIND_ACK     = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SELECTIVE_MODE = 2'd0,
    REG_WINDOW_SIZE    = 2'd1
  } arqrw_cfg_reg_e;

  // Packet control info handed from front to back.
  typedef struct packed {
    logic [SEQ_W-1:0] seq;
    logic             in_space;
  } arqrw_ctl_t;

  // Live configuration.
  typedef struct packed {
    logic             selective;
    logic [WIN_W-1:0] window;
  } arqrw_cfg_t;

endpackage

`default_nettype wire

FILE: rtl/arqrw_ifs.sv
// ----------------------------------------------------------------------------
// arqrw_ifs
// Valid/ready channels: received packets, results and register writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface arqrw_pkt_if #(
  parameter int PAYLOAD_WIDTH = arqrw_pkg::DEF_PAYLOAD_WIDTH
);
  logic                           valid;
  logic                           ready;
  logic [arqrw_pkg::SEQ_W-1:0]    seq_number;
  logic                           checksum_good;
  logic [PAYLOAD_WIDTH-1:0]       payload_word;

  modport source (output valid, seq_number, checksum_good, payload_word, input ready);
  modport sink   (input valid, seq_number, checksum_good, payload_word, output ready);
endinterface

interface arqrw_res_if #(
  parameter int PAYLOAD_WIDTH = arqrw_pkg::DEF_PAYLOAD_WIDTH
);
  logic                               valid;
  logic                               ready;
  logic                               kind;
  logic [PAYLOAD_WIDTH-1:0]           delivered_data;
  logic signed [arqrw_pkg::ACK_W-1:0] ack_number;
  logic                               last_of_run;

  modport source (output valid, kind, delivered_data, ack_number, last_of_run, input ready);
  modport sink   (input valid, kind, delivered_data, ack_number, last_of_run, output ready);
endinterface

interface arqrw_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [arqrw_pkg::CFG_IDX_W-1:0]  index;
  logic [arqrw_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

FILE: rtl/arq_receiver_window_unit.sv
// A good packet's first result passes the queue, the decode step and the output
//   register; a bad-checksum packet gives none.
// The back end takes one packet at a time: a decode step, then one result per
//   cycle while the output is not stalled; in order, up to 3 buffered deliveries.
// Reset (rst, synchronous): clears queue, window state, ack (-1) and config;
//   the slot RAM is not cleared, the slot valid bits guard it.
// ----------------------------------------------------------------------------
// arq_receiver_window_unit
// Receive side of a sliding-window ARQ link, stop-and-wait or selective
// repeat, with an input queue decoupling acceptance from result output.
// ----------------------------------------------------------------------------
`default_nettype none

module arq_receiver_window_unit #(
  parameter int SEQ_SPACE     = arqrw_pkg::DEF_SEQ_SPACE,
  parameter int PAYLOAD_WIDTH = arqrw_pkg::DEF_PAYLOAD_WIDTH
) (
  input  logic         clk,
  input  logic         rst,
  arqrw_pkt_if.sink    pkt,
  arqrw_res_if.source  res,
  arqrw_cfg_if.sink    cfg
);

  import arqrw_pkg::*;

  // Configuration registers. Writes are only expected while the unit is
  // idle, so the back end sees them as static for the whole packet.
  arqrw_cfg_t cfg_reg;

  // Front-to-back queue head.
  logic                     q_valid;
  logic                     q_ready;
  arqrw_ctl_t               q_ctl;
  logic [PAYLOAD_WIDTH-1:0] q_data;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_reg.selective <= 1'b0;
      cfg_reg.window    <= WIN_RESET;
    end else if (cfg.valid) begin
      case (arqrw_cfg_reg_e'(cfg.index))
        REG_SELECTIVE_MODE: cfg_reg.selective <= cfg.data[0];
        REG_WINDOW_SIZE:    cfg_reg.window    <= cfg.data[WIN_W-1:0];
        default: begin
          // unmapped index: write dropped
        end
      endcase
    end
  end

  // Front: checksum filter, range check, 2-word queue. It keeps accepting, until
  // the queue is full, while the back end is busy emitting the previous packet's results.
  arqrw_front #(
    .SEQ_SPACE     (SEQ_SPACE),
    .PAYLOAD_WIDTH (PAYLOAD_WIDTH)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .pkt     (pkt),
    .q_valid (q_valid),
    .q_ctl   (q_ctl),
    .q_data  (q_data),
    .q_ready (q_ready)
  );

  // Back: window state machine, slot RAM and the output register. One
  // packet at a time; drain reads one buffered slot per cycle unless stalled.
  arqrw_back #(
    .SEQ_SPACE     (SEQ_SPACE),
    .PAYLOAD_WIDTH (PAYLOAD_WIDTH)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg_reg),
    .q_valid (q_valid),
    .q_ctl   (q_ctl),
    .q_data  (q_data),
    .q_ready (q_ready),
    .res     (res)
  );

endmodule

`default_nettype wire

FILE: rtl/arqrw_ram.sv
// ----------------------------------------------------------------------------
// arqrw_ram
// Generic one-write, one-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module arqrw_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: rtl/arqrw_front.sv
// ----------------------------------------------------------------------------
// arqrw_front
// Input side: drops bad-checksum packets, classifies the sequence number
// and queues good packets for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module arqrw_front #(
  parameter int SEQ_SPACE     = arqrw_pkg::DEF_SEQ_SPACE,
  parameter int PAYLOAD_WIDTH = arqrw_pkg::DEF_PAYLOAD_WIDTH
) (
  input  logic                  clk,
  input  logic                  rst,
  arqrw_pkt_if.sink             pkt,
  output logic                  q_valid,
  output arqrw_pkg::arqrw_ctl_t q_ctl,
  output logic [PAYLOAD_WIDTH-1:0] q_data,
  input  logic                  q_ready
);

  import arqrw_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = PTR_W + 1;

  arqrw_ctl_t               ctl_mem  [QUEUE_DEPTH];
  logic [PAYLOAD_WIDTH-1:0] data_mem [QUEUE_DEPTH];
  logic [PTR_W-1:0]         wr_ptr;
  logic [PTR_W-1:0]         rd_ptr;
  logic [CNT_W-1:0]         count;
  logic [CNT_W-1:0]         count_next;
  logic                     push;
  logic                     pop;
  arqrw_ctl_t               in_ctl;

  assign pkt.ready = (count != CNT_W'(QUEUE_DEPTH));
  assign push      = pkt.valid && pkt.ready && pkt.checksum_good;
  assign q_valid   = (count != '0);
  assign pop       = q_valid && q_ready;
  assign q_ctl     = ctl_mem[rd_ptr];
  assign q_data    = data_mem[rd_ptr];

  // Numbers outside the sequence space never match and never buffer.
  always_comb begin
    in_ctl.seq      = pkt.seq_number;
    in_ctl.in_space = (32'(pkt.seq_number) < SEQ_SPACE);
  end

  always_comb begin
    case ({push, pop})
      2'b10:   count_next = count + 1'b1;
      2'b01:   count_next = count - 1'b1;
      default: count_next = count;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      count <= count_next;
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ctl_mem[wr_ptr]  <= in_ctl;
      data_mem[wr_ptr] <= pkt.payload_word;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/arqrw_back.sv
// ----------------------------------------------------------------------------
// arqrw_back
// Window sequencer: delivers, acks, buffers and drains queued packets,
// one result word per cycle into the output register while it is free.
// ----------------------------------------------------------------------------
`default_nettype none

module arqrw_back #(
  parameter int SEQ_SPACE     = arqrw_pkg::DEF_SEQ_SPACE,
  parameter int PAYLOAD_WIDTH = arqrw_pkg::DEF_PAYLOAD_WIDTH
) (
  input  logic                     clk,
  input  logic                     rst,
  input  arqrw_pkg::arqrw_cfg_t    cfg,
  input  logic                     q_valid,
  input  arqrw_pkg::arqrw_ctl_t    q_ctl,
  input  logic [PAYLOAD_WIDTH-1:0] q_data,
  output logic                     q_ready,
  arqrw_res_if.source              res
);

  import arqrw_pkg::*;

  localparam int IDX_W = $clog2(SEQ_SPACE);
  localparam int D_W   = IDX_W + 1;
  localparam int CAP   = (SEQ_SPACE / 2 > WIN_MAX) ? WIN_MAX : SEQ_SPACE / 2;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_DELIV = 5'b00010,   // in-order packet delivery
    S_ACK   = 5'b00100,   // ack of in-order packet
    S_DRAIN = 5'b01000,   // buffered deliveries
    S_OACK  = 5'b10000    // out-of-order ack (and buffering)
  } state_t;

  state_t                   state;
  state_t                   state_next;
  arqrw_ctl_t               cur_ctl;
  logic [PAYLOAD_WIDTH-1:0] cur_data;
  logic [IDX_W-1:0]         expected;
  logic [IDX_W-1:0]         expected_next;
  logic signed [ACK_W-1:0]  last_ack;
  logic signed [ACK_W-1:0]  last_ack_next;
  logic [SEQ_SPACE-1:0]     filled;
  logic [SEQ_SPACE-1:0]     filled_next;
  logic [1:0]               cnt;
  logic [1:0]               cnt_next;

  logic                     res_valid;
  logic                     res_kind;
  logic [PAYLOAD_WIDTH-1:0] res_data;
  logic signed [ACK_W-1:0]  res_ack;
  logic                     res_last;

  logic                     o_kind;
  logic [PAYLOAD_WIDTH-1:0] o_data;
  logic signed [ACK_W-1:0]  o_ack;
  logic                     o_last;

  logic [WIN_W-1:0]         win;
  logic [IDX_W-1:0]         exp_inc;
  logic [IDX_W-1:0]         cur_idx;
  logic [D_W-1:0]           diff;
  logic [D_W-1:0]           fwd_dist;
  logic                     in_win;
  logic                     more_ack;
  logic                     more_drain;
  logic                     emit_ok;
  logic                     emit;
  logic                     ram_we;
  logic [IDX_W-1:0]         ram_raddr;
  logic [PAYLOAD_WIDTH-1:0] ram_rdata;
  logic signed [ACK_W-1:0]  cur_ack;

  // Window clamped to 1..min(4, SEQ_SPACE/2).
  always_comb begin
    if (cfg.window > WIN_W'(CAP)) begin
      win = WIN_W'(CAP);
    end else if (cfg.window == '0) begin
      win = WIN_W'(1);
    end else begin
      win = cfg.window;
    end
  end

  assign exp_inc  = (expected == IDX_W'(SEQ_SPACE - 1)) ? '0 : expected + 1'b1;
  assign cur_idx  = IDX_W'(cur_ctl.seq);
  assign cur_ack  = ACK_W'(cur_ctl.seq);
  assign diff     = {1'b0, cur_idx} - {1'b0, expected};
  assign fwd_dist = diff[IDX_W] ? diff + D_W'(SEQ_SPACE) : diff;
  assign in_win   = (32'(fwd_dist) < 32'(win));
  assign more_ack   = cfg.selective && (win > WIN_W'(1)) && filled[expected];
  assign more_drain = ((WIN_W'(cnt) + WIN_W'(2)) < win) && filled[exp_inc];

  assign emit_ok = !res_valid || res.ready;
  assign emit    = emit_ok && (state != S_IDLE);
  assign q_ready = (state == S_IDLE);

  assign ram_we    = (state == S_OACK) && emit_ok && cfg.selective
                     && cur_ctl.in_space && in_win;
  assign ram_raddr = ((state == S_DRAIN) && emit_ok) ? exp_inc : expected;

  always_comb begin
    state_next    = state;
    expected_next = expected;
    last_ack_next = last_ack;
    filled_next   = filled;
    cnt_next      = cnt;
    o_kind        = KIND_DELIVER;
    o_data        = '0;
    o_ack         = '0;
    o_last        = 1'b0;
    case (state)
      S_IDLE: begin
        if (q_valid) begin
          if (q_ctl.in_space && (IDX_W'(q_ctl.seq) == expected)) begin
            state_next = S_DELIV;
          end else begin
            state_next = S_OACK;
          end
        end
      end
      S_DELIV: begin
        o_data = cur_data;
        if (emit_ok) begin
          last_ack_next = cur_ack;
          expected_next = exp_inc;
          if (cfg.selective) begin
            filled_next[expected] = 1'b0;
          end
          state_next = S_ACK;
        end
      end
      S_ACK: begin
        o_kind = KIND_ACK;
        o_ack  = last_ack;
        o_last = !more_ack;
        if (emit_ok) begin
          cnt_next   = '0;
          state_next = more_ack ? S_DRAIN : S_IDLE;
        end
      end
      S_DRAIN: begin
        o_data = ram_rdata;
        o_last = !more_drain;
        if (emit_ok) begin
          filled_next[expected] = 1'b0;
          expected_next         = exp_inc;
          cnt_next              = cnt + 1'b1;
          state_next            = more_drain ? S_DRAIN : S_IDLE;
        end
      end
      S_OACK: begin
        o_kind = KIND_ACK;
        o_ack  = cfg.selective ? cur_ack : last_ack;
        o_last = 1'b1;
        if (emit_ok) begin
          if (cfg.selective) begin
            last_ack_next = cur_ack;
            if (cur_ctl.in_space && in_win) begin
              filled_next[cur_idx] = 1'b1;
            end
          end
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      expected  <= '0;
      last_ack  <= ACK_NONE;
      filled    <= '0;
      cnt       <= '0;
      res_valid <= 1'b0;
    end else begin
      state    <= state_next;
      expected <= expected_next;
      last_ack <= last_ack_next;
      filled   <= filled_next;
      cnt      <= cnt_next;
      if (emit) begin
        res_valid <= 1'b1;
      end else if (res.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_valid && q_ready) begin
      cur_ctl  <= q_ctl;
      cur_data <= q_data;
    end
    if (emit) begin
      res_kind <= o_kind;
      res_data <= o_data;
      res_ack  <= o_ack;
      res_last <= o_last;
    end
  end

  arqrw_ram #(
    .WIDTH (PAYLOAD_WIDTH),
    .DEPTH (SEQ_SPACE)
  ) u_slot_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (cur_idx),
    .wdata (cur_data),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign res.valid          = res_valid;
  assign res.kind           = res_kind;
  assign res.delivered_data = res_data;
  assign res.ack_number     = res_ack;
  assign res.last_of_run    = res_last;

endmodule

`default_nettype wire

FILE: rtl/arqrw_checker.sv
// ----------------------------------------------------------------------------
// arqrw_checker
// Port-level checks on the result channel of the receiver window unit.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module arqrw_checker #(
  parameter int DATA_W = arqrw_pkg::DEF_PAYLOAD_WIDTH
) (
  input logic                              clk,
  input logic                              rst,
  input logic                              res_valid,
  input logic                              res_ready,
  input logic                              res_kind,
  input logic [DATA_W-1:0]                 res_data,
  input logic signed [arqrw_pkg::ACK_W-1:0] res_ack,
  input logic                              res_last
);

  import arqrw_pkg::*;

  // Stalled result word holds.
  `CHK_ASSERT(a_res_hold, clk, rst, res_valid && !res_ready |=> res_valid && $stable(res_kind) && $stable(res_data) && $stable(res_ack) && $stable(res_last))

  // Reset empties the output register.
  `CHK_ASSERT_NR(a_res_reset, clk, rst |=> !res_valid)

  // Unused fields are zero: no data on acks, no ack on deliveries.
  `CHK_ASSERT(a_unused_zero, clk, rst, res_valid |-> (res_kind == KIND_ACK && res_data == '0) || (res_kind == KIND_DELIVER && res_ack == '0))

  // The only negative ack is the initial -1.
  `CHK_ASSERT(a_ack_range, clk, rst, res_valid && res_ack[ACK_W-1] |-> res_ack == ACK_NONE)

endmodule

bind arq_receiver_window_unit arqrw_checker #(
  .DATA_W (PAYLOAD_WIDTH)
) u_checker (
  .clk       (clk),
  .rst       (rst),
  .res_valid (res.valid),
  .res_ready (res.ready),
  .res_kind  (res.kind),
  .res_data  (res.delivered_data),
  .res_ack   (res.ack_number),
  .res_last  (res.last_of_run)
);

`default_nettype wire

FILE: verif/arq_receiver_window_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arq_receiver_window_unit_test
// Self-checking bench for the ARQ receiver window unit. A directed list of
// packets and register writes is walked first, then random bursts in both
// receive modes. Every result word is compared, in order and field by field,
// against the words owed by an in-bench window model or the directed list.
// ----------------------------------------------------------------------------

module arq_receiver_window_unit_test;
  import arqrw_pkg::*;

  localparam int PW              = DEF_PAYLOAD_WIDTH;
  localparam int SETTLE_CYCLES   = 12;       // > queue + decode + output reg
  localparam int HOLD_CYCLES     = 150;      // long result back-pressure
  localparam int N_PHASES        = 6;
  localparam int ITEMS_PER_PHASE = 47;       // ~305 random + directed
  localparam int MAX_PRINTS      = 20;
  localparam longint TIMEOUT_NS  = 64'd5_000_000;

  // Index that maps to no register; writes to it must be ignored.
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 2'd3;

  // One result word as the unit emits it.
  typedef struct packed {
    logic                    kind;
    logic [PW-1:0]           data;
    logic signed [ACK_W-1:0] ack;
    logic                    last;
  } reply_t;

  // Directed step: either a register write or a packet; typed_n >= 0 means
  // the expected words are spelled out here instead of taken from the model.
  typedef struct {
    bit                    is_reg;
    logic [CFG_IDX_W-1:0]  reg_idx;
    logic [CFG_DATA_W-1:0] reg_val;
    logic [SEQ_W-1:0]      seq;
    logic                  good;
    logic [PW-1:0]         word;
    int                    typed_n;
    reply_t                typed0;
    reply_t                typed1;
  } stim_row_t;

  localparam reply_t NO_REPLY = '0;

  logic clk = 1'b0;
  logic rst = 1'b1;

  arqrw_pkt_if #(.PAYLOAD_WIDTH(PW)) pkt ();
  arqrw_res_if #(.PAYLOAD_WIDTH(PW)) res ();
  arqrw_cfg_if                       cfg ();

  arq_receiver_window_unit #(
    .SEQ_SPACE     (DEF_SEQ_SPACE),
    .PAYLOAD_WIDTH (PW)
  ) i_dut (
    .clk (clk),
    .rst (rst),
    .pkt (pkt),
    .res (res),
    .cfg (cfg)
  );

  always #5 clk = ~clk;

  // --------------------------------------------------------------------------
  // Window model state (mirrors the receiver, updated at word acceptance)
  // --------------------------------------------------------------------------
  logic                    sel_mode;
  logic [WIN_W-1:0]        win_reg;
  logic [SEQ_W-1:0]        exp_seq;
  logic signed [ACK_W-1:0] last_ack_m;
  logic                    slot_full [DEF_SEQ_SPACE];
  logic [PW-1:0]           slot_word [DEF_SEQ_SPACE];

  reply_t model_out [5];
  int     model_n;

  reply_t    pending_replies [$];   // words still owed by the unit
  stim_row_t stim_rows [$];

  int mismatches  = 0;
  int good_sent   = 0;
  int dropped     = 0;
  int words_seen  = 0;
  int long_runs   = 0;              // packets that released buffered words

  // Sender / receiver pacing knobs, changed per phase.
  bit src_calm  = 1'b0;
  bit sink_calm = 1'b0;
  bit hold_req  = 1'b0;

  function automatic reply_t mk_reply(input logic kind, input logic [PW-1:0] data,
                                      input logic signed [ACK_W-1:0] ack,
                                      input logic last);
    reply_t r;
    r.kind = kind;
    r.data = data;
    r.ack  = ack;
    r.last = last;
    return r;
  endfunction

  // Window width after saturation into 1..WIN_MAX (= half the seq space).
  function automatic int win_eff();
    if (win_reg > WIN_MAX) return WIN_MAX;
    if (win_reg == '0) return 1;
    return int'(win_reg);
  endfunction

  // Receiver model: fills model_out/model_n for one accepted packet.
  function automatic void predict_packet(input logic [SEQ_W-1:0] seq, input logic good,
                                         input logic [PW-1:0] word);
    int               w;
    int               i;
    logic [SEQ_W-1:0] fwd_dist;
    model_n = 0;
    if (!good) return;  // bad checksum: silent, no state change
    w = win_eff();
    if (seq == exp_seq) begin
      model_out[model_n] = mk_reply(KIND_DELIVER, word, '0, 1'b0);
      model_n++;
      last_ack_m = signed'({1'b0, seq});
      model_out[model_n] = mk_reply(KIND_ACK, '0, last_ack_m, 1'b0);
      model_n++;
      exp_seq = exp_seq + 1'b1;
      if (sel_mode) begin
        slot_full[seq] = 1'b0;
        // release buffered successors, at most w-1 of them
        i = 0;
        while (i + 1 < w && slot_full[exp_seq]) begin
          model_out[model_n] = mk_reply(KIND_DELIVER, slot_word[exp_seq], '0, 1'b0);
          model_n++;
          slot_full[exp_seq] = 1'b0;
          exp_seq = exp_seq + 1'b1;
          i++;
        end
      end
    end else begin
      if (sel_mode) begin
        fwd_dist = seq - exp_seq;
        if (int'(fwd_dist) < w) begin
          slot_full[seq] = 1'b1;
          slot_word[seq] = word;
        end
        last_ack_m = signed'({1'b0, seq});
      end
      // stop-and-wait just repeats the previous ack
      model_out[model_n] = mk_reply(KIND_ACK, '0, last_ack_m, 1'b0);
      model_n++;
    end
    model_out[model_n-1].last = 1'b1;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [PW-1:0] rand_word();
    int r;
    r = $urandom_range(0, 99);
    if (r < 3) return '0;
    if (r < 6) return '1;
    return {$urandom, $urandom};
  endfunction

  function automatic void add_reg(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] val);
    stim_row_t row;
    row = '{default: '0};
    row.is_reg  = 1'b1;
    row.reg_idx = idx;
    row.reg_val = val;
    stim_rows.push_back(row);
  endfunction

  function automatic void add_typed(input logic [SEQ_W-1:0] seq, input logic good,
                                    input logic [PW-1:0] word, input int n,
                                    input reply_t r0, input reply_t r1);
    stim_row_t row;
    row = '{default: '0};
    row.seq     = seq;
    row.good    = good;
    row.word    = word;
    row.typed_n = n;
    row.typed0  = r0;
    row.typed1  = r1;
    stim_rows.push_back(row);
  endfunction

  function automatic void add_pkt(input logic [SEQ_W-1:0] seq, input logic [PW-1:0] word);
    add_typed(seq, 1'b1, word, -1, NO_REPLY, NO_REPLY);
  endfunction

  task automatic report_mismatch(input string what, input logic [PW-1:0] got,
                                 input logic [PW-1:0] want);
    if (mismatches < MAX_PRINTS)
      $display("%0t ns: MISMATCH %s: got %h want %h", $time, what, got, want);
    mismatches++;
  endtask

  // --------------------------------------------------------------------------
  // Driving
  // --------------------------------------------------------------------------

  // Offer one packet; on acceptance run the model and queue what is owed.
  task automatic send_packet(input logic [SEQ_W-1:0] seq, input logic good,
                             input logic [PW-1:0] word, input int typed_n,
                             input reply_t t0, input reply_t t1);
    int gap;
    int i;
    gap = src_calm ? 0 : pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      pkt.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    pkt.valid         <= 1'b1;
    pkt.seq_number    <= seq;
    pkt.checksum_good <= good;
    pkt.payload_word  <= word;
    @(posedge clk);
    while (!pkt.ready) @(posedge clk);
    predict_packet(seq, good, word);
    if (good) good_sent++;
    else dropped++;
    if (model_n > 2) long_runs++;
    if (typed_n < 0) begin
      for (i = 0; i < model_n; i++) pending_replies.push_back(model_out[i]);
    end else begin
      if (typed_n > 0) pending_replies.push_back(t0);
      if (typed_n > 1) pending_replies.push_back(t1);
    end
  endtask

  // Bring the unit to idle: all owed words in, then room for a silent
  // (bad checksum) packet still working its way through.
  task automatic settle();
    @(negedge clk);
    pkt.valid <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= val;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    if (idx == REG_SELECTIVE_MODE) sel_mode = val[0];
    else if (idx == REG_WINDOW_SIZE) win_reg = val;
    @(negedge clk);
    cfg.valid <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Result side: random back-pressure, plus one long hold-off on request
  // --------------------------------------------------------------------------
  initial begin
    int stall;
    int n;
    res.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        // sender keeps offering meanwhile: the input queue fills and stalls
        res.ready <= 1'b0;
        for (n = 0; n < HOLD_CYCLES; n++) @(negedge clk);
        hold_req = 1'b0;
        res.ready <= 1'b1;
      end else if (sink_calm || $urandom_range(0, 3) != 0) begin
        res.ready <= 1'b1;
      end else begin
        res.ready <= 1'b0;
        stall = pick_gap() + 1;
        repeat (stall) @(negedge clk);
      end
    end
  end

  // Checker: every accepted result word against the oldest owed one.
  always @(posedge clk) begin
    reply_t want;
    if (!rst && res.valid && res.ready) begin
      words_seen++;
      if (pending_replies.size() == 0) begin
        report_mismatch("unexpected result word, kind", res.kind, 'x);
      end else begin
        want = pending_replies.pop_front();
        if (res.kind !== want.kind)
          report_mismatch("kind", res.kind, want.kind);
        if (res.delivered_data !== want.data)
          report_mismatch("delivered_data", res.delivered_data, want.data);
        if (res.ack_number !== want.ack)
          report_mismatch("ack_number", res.ack_number, want.ack);
        if (res.last_of_run !== want.last)
          report_mismatch("last_of_run", res.last_of_run, want.last);
      end
    end
  end

  // Hard stop in case the unit hangs.
  initial begin
    #(TIMEOUT_NS);
    $display("Timeout after %0d ns, %0d words still owed", TIMEOUT_NS,
             pending_replies.size());
    $display("Mismatches found");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    stim_row_t        row;
    int               ph;
    int               target;
    int               w;
    int               k;
    int               j;
    int               t;
    int               offs [WIN_MAX];
    int               r;
    logic [SEQ_W-1:0] base;
    logic [SEQ_W-1:0] s;

    pkt.valid         = 1'b0;
    pkt.seq_number    = '0;
    pkt.checksum_good = 1'b0;
    pkt.payload_word  = '0;
    cfg.valid         = 1'b0;
    cfg.index         = '0;
    cfg.data          = '0;

    // model reset state
    sel_mode   = 1'b0;
    win_reg    = WIN_RESET;
    exp_seq    = '0;
    last_ack_m = ACK_NONE;
    for (k = 0; k < DEF_SEQ_SPACE; k++) begin
      slot_full[k] = 1'b0;
      slot_word[k] = '0;
    end

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // ---- directed list (starts in stop-and-wait, window 4) ----
    // nothing accepted yet: out-of-order ack carries -1
    add_typed(3'd3, 1'b1, '0, 1, mk_reply(KIND_ACK, '0, ACK_NONE, 1'b1), NO_REPLY);
    // bad checksum is silent
    add_typed(3'd0, 1'b0, '1, 0, NO_REPLY, NO_REPLY);
    // in order, all-ones payload: deliver then ack 0
    add_typed(3'd0, 1'b1, '1, 2, mk_reply(KIND_DELIVER, '1, '0, 1'b0),
              mk_reply(KIND_ACK, '0, 4'sd0, 1'b1));
    // duplicate in stop-and-wait repeats ack 0
    add_typed(3'd0, 1'b1, '0, 1, mk_reply(KIND_ACK, '0, 4'sd0, 1'b1), NO_REPLY);
    add_pkt(3'd1, 64'hA5A5_5A5A_0F0F_F0F0);
    add_pkt(3'd7, 64'h3C3C_C3C3_1234_5678);
    add_reg(REG_UNMAPPED, 3'd7);                 // ignored write
    add_pkt(3'd2, 64'h0123_4567_89AB_CDEF);
    add_reg(REG_SELECTIVE_MODE, 3'd1);
    add_reg(REG_WINDOW_SIZE, 3'd7);              // saturates to 4
    // fill the window out of order, one beyond it, then the gap: 5 words
    add_pkt(3'd5, 64'h5555_0000_5555_0000);
    add_pkt(3'd4, 64'h4444_FFFF_4444_FFFF);
    add_pkt(3'd6, 64'h6666_AAAA_6666_AAAA);
    add_pkt(3'd7, 64'h7777_7777_7777_7777);
    add_pkt(3'd3, 64'hFEDC_BA98_7654_3210);
    add_typed(3'd7, 1'b0, 64'h8000_0000_0000_0001, 0, NO_REPLY, NO_REPLY);
    add_reg(REG_WINDOW_SIZE, 3'd0);              // saturates to 1
    add_pkt(3'd0, 64'h0000_0000_0000_0001);
    add_pkt(3'd7, 64'h8000_0000_0000_0000);
    add_reg(REG_WINDOW_SIZE, 3'd1);
    add_pkt(3'd1, 64'hDEAD_BEEF_CAFE_F00D);
    add_pkt(3'd0, 64'h0F0F_0F0F_0F0F_0F0F);
    add_reg(REG_WINDOW_SIZE, 3'd2);
    add_pkt(3'd2, 64'hF0F0_F0F0_F0F0_F0F0);
    add_pkt(3'd1, 64'h1111_2222_3333_4444);
    add_pkt(3'd4, 64'hAAAA_5555_AAAA_5555);   // buffered
    // mode switch keeps slot 4 but stop-and-wait ignores it
    add_reg(REG_SELECTIVE_MODE, 3'd0);
    add_pkt(3'd5, 64'h9999_8888_7777_6666);
    add_pkt(3'd3, 64'h5A5A_A5A5_5A5A_A5A5);
    add_reg(REG_SELECTIVE_MODE, 3'd1);
    add_pkt(3'd4, 64'h0000_FFFF_0000_FFFF);   // fresh data wins over slot

    foreach (stim_rows[i]) begin
      row = stim_rows[i];
      if (row.is_reg) begin
        settle();
        write_reg(row.reg_idx, row.reg_val);
      end else begin
        send_packet(row.seq, row.good, row.word, row.typed_n, row.typed0, row.typed1);
      end
    end

    // ---- random phases ----
    for (ph = 0; ph < N_PHASES; ph++) begin
      settle();
      case (ph)
        0: begin write_reg(REG_SELECTIVE_MODE, 3'd1); write_reg(REG_WINDOW_SIZE, 3'd4); end
        1: begin write_reg(REG_SELECTIVE_MODE, 3'd1); write_reg(REG_WINDOW_SIZE, 3'd1); end
        2: begin write_reg(REG_SELECTIVE_MODE, 3'd0); write_reg(REG_WINDOW_SIZE, 3'd2); end
        3: begin write_reg(REG_SELECTIVE_MODE, 3'd1); write_reg(REG_WINDOW_SIZE, 3'd7); end
        default: begin
          write_reg(REG_SELECTIVE_MODE, CFG_DATA_W'($urandom_range(0, 1)));
          write_reg(REG_WINDOW_SIZE, CFG_DATA_W'($urandom_range(0, 7)));
        end
      endcase
      src_calm  = (ph % 3 == 2);
      sink_calm = src_calm;
      if (ph == 3) begin
        src_calm = 1'b1;
        hold_req = 1'b1;
      end
      target = good_sent + ITEMS_PER_PHASE;
      while (good_sent < target) begin
        if (sel_mode) begin
          // one window worth, shuffled, with some noise numbers mixed in
          base = exp_seq;
          w    = win_eff();
          for (k = 0; k < w; k++) offs[k] = k;
          for (k = w - 1; k > 0; k--) begin
            j       = $urandom_range(0, k);
            t       = offs[k];
            offs[k] = offs[j];
            offs[j] = t;
          end
          for (k = 0; k < w; k++) begin
            if ($urandom_range(0, 99) < 12) s = SEQ_W'($urandom_range(0, 7));
            else s = base + SEQ_W'(offs[k]);
            send_packet(s, $urandom_range(0, 99) >= 8, rand_word(), -1,
                        NO_REPLY, NO_REPLY);
          end
        end else begin
          // stop-and-wait: mostly in order, some duplicates and strays
          r = $urandom_range(0, 99);
          if (r < 70) s = exp_seq;
          else if (r < 85) s = exp_seq - 1'b1;
          else s = SEQ_W'($urandom_range(0, 7));
          send_packet(s, $urandom_range(0, 99) >= 8, rand_word(), -1,
                      NO_REPLY, NO_REPLY);
        end
      end
    end

    settle();

    $display("Covered %0d good packets and %0d bad-checksum drops, %0d result words,",
             good_sent, dropped, words_seen);
    $display("both receive modes, windows 0..7 with saturation, %0d chained releases",
             long_runs);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
